>>> rtl/core/btb_two_level_branch_predictor_defines.svh
// Assertion macros shared by the branch predictor RTL
`ifndef BTB_TWO_LEVEL_BRANCH_PREDICTOR_DEFINES_SVH
`define BTB_TWO_LEVEL_BRANCH_PREDICTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BTB_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BTB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/btb_pkg.sv
// Package: shared constants, word types and control structs of the branch predictor
`timescale 1ns / 1ps
`default_nettype none
package btb_pkg;

    localparam int BTB_MAX_ENTRIES = 32;
    localparam int BTB_MAX_HISTORY = 8;
    localparam int BTB_PC_W        = 32;
    localparam int BTB_TAG_W       = 30;
    localparam int BTB_CNT_W       = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_BITS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_HIST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_TABLE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE_MODE    = 3'd6;

    // history/pc sharing modes
    localparam logic [1:0] SHARE_NONE = 2'd0;
    localparam logic [1:0] SHARE_LOW  = 2'd1;
    localparam logic [1:0] SHARE_HIGH = 2'd2;

    localparam logic FUNC_PREDICT = 1'b0;
    localparam logic FUNC_UPDATE  = 1'b1;

    // 2-bit saturating counter limits
    localparam logic [1:0] CNT_MIN = 2'd0;
    localparam logic [1:0] CNT_MAX = 2'd3;

    localparam int TAG_SHIFT_MAX = 30;
    localparam logic [BTB_PC_W-1:0] PC_STEP = 32'd4;

    typedef struct packed {
        logic                func;
        logic [BTB_PC_W-1:0] pc;
        logic [BTB_PC_W-1:0] target;
        logic                taken;
        logic [BTB_PC_W-1:0] pred_next;
    } t_req;

    typedef struct packed {
        logic                 pred_taken;
        logic [BTB_PC_W-1:0]  next_pc;
        logic                 mispredicted;
        logic [BTB_CNT_W-1:0] branch_count;
        logic [BTB_CNT_W-1:0] flush_count;
    } t_rsp;

    typedef struct packed {
        logic clear;
        logic fill;
        logic capture;
        logic lookup;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic init_wr;
        logic need_fill;
        logic fill_last;
        logic clear_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/core/btb_ifs.sv
// Interfaces: request and response word channels
`timescale 1ns / 1ps
`default_nettype none
interface btb_req_if import btb_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface btb_rsp_if import btb_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/btb_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module btb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/btb_ctrl.sv
// Controller: sequencing state machine for clear, lookup, slab fill and training
`timescale 1ns / 1ps
`default_nettype none
`include "btb_two_level_branch_predictor_defines.svh"
module btb_ctrl import btb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_TAG   = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_ADDR  = 3'd4;
    localparam logic [2:0] S_COUNT = 3'd5;

    logic [2:0] r_state, n_state;
    logic       w_accept;

    // take a word only when idle and no table refill is being requested
    assign o_req_ready = (r_state == S_IDLE) && !i_sts.init_wr;
    assign w_accept    = o_req_ready && i_req_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last && !i_sts.init_wr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_sts.init_wr) n_state = S_CLEAR;
                else if (w_accept) n_state = S_TAG;
            end
            S_TAG: begin
                n_state = i_sts.need_fill ? S_FILL : S_ADDR;
            end
            S_FILL: begin
                if (i_sts.fill_last) n_state = S_ADDR;
            end
            S_ADDR: begin
                n_state = S_COUNT;
            end
            S_COUNT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // decode commands for the datapath
    always_comb begin
        o_cmd.clear   = (r_state == S_CLEAR);
        o_cmd.fill    = (r_state == S_FILL);
        o_cmd.capture = w_accept;
        o_cmd.lookup  = (r_state == S_TAG);
        o_cmd.finish  = (r_state == S_COUNT) && i_sts.out_free;
    end

    `BTB_ASSERT_NEXT(a_accept_tag, i_clk, i_rst_n, w_accept, r_state == S_TAG, "accept did not start lookup")
    `BTB_ASSERT_NEXT(a_miss_fill, i_clk, i_rst_n, (r_state == S_TAG) && i_sts.need_fill, r_state == S_FILL, "allocation skipped slab fill")
    `BTB_ASSERT_NEXT(a_finish_idle, i_clk, i_rst_n, o_cmd.finish, r_state == S_IDLE, "finish did not return to idle")
endmodule
`default_nettype wire

>>> rtl/core/btb_dp.sv
// Datapath: configuration, entry store, counter tables, counts and result register
`timescale 1ns / 1ps
`default_nettype none
`include "btb_two_level_branch_predictor_defines.svh"
module btb_dp import btb_pkg::*; #(
    parameter int MAX_ENTRIES = BTB_MAX_ENTRIES,
    parameter int MAX_HISTORY = BTB_MAX_HISTORY
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_req                  i_req_data,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    output logic                       o_rsp_valid,
    output t_rsp                       o_rsp_data,
    input  wire logic                  i_rsp_ready
);
    localparam int HW      = MAX_HISTORY;
    localparam int SLAB    = 1 << MAX_HISTORY;
    localparam int EW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LDEPTH  = MAX_ENTRIES * SLAB;
    localparam int LAW     = $clog2(LDEPTH);
    localparam int EIB_MAX = $clog2(MAX_ENTRIES + 1) - 1;
    localparam int EWIDTH  = BTB_TAG_W + BTB_PC_W + HW;

    // configuration registers
    logic [2:0] r_cfg_ib;
    logic [3:0] r_cfg_hb;
    logic [4:0] r_cfg_tb;
    logic [1:0] r_cfg_init;
    logic       r_cfg_gh;
    logic       r_cfg_gt;
    logic [1:0] r_cfg_sm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ib   <= 3'd0;
            r_cfg_hb   <= 4'd1;
            r_cfg_tb   <= 5'd0;
            r_cfg_init <= 2'd1;
            r_cfg_gh   <= 1'b0;
            r_cfg_gt   <= 1'b0;
            r_cfg_sm   <= SHARE_NONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INDEX_BITS:    r_cfg_ib   <= i_cfg_data[2:0];
                CFG_HISTORY_BITS:  r_cfg_hb   <= i_cfg_data[3:0];
                CFG_TAG_BITS:      r_cfg_tb   <= i_cfg_data[4:0];
                CFG_INITIAL_STATE: r_cfg_init <= i_cfg_data[1:0];
                CFG_GLOBAL_HIST:   r_cfg_gh   <= i_cfg_data[0];
                CFG_GLOBAL_TABLE:  r_cfg_gt   <= i_cfg_data[0];
                CFG_SHARE_MODE:    r_cfg_sm   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic w_init_wr;
    assign w_init_wr = i_cfg_we && (i_cfg_idx == CFG_INITIAL_STATE);

    // effective field widths
    logic [2:0]  w_ib;
    logic [4:0]  w_tb;
    logic [4:0]  w_hb;
    logic [HW:0] w_hm_full;
    logic [HW-1:0] w_hm;

    always_comb begin
        w_ib = r_cfg_ib;
        if (EIB_MAX < 7 && r_cfg_ib > 3'(EIB_MAX)) w_ib = 3'(EIB_MAX);
        w_tb = (r_cfg_tb > 5'(TAG_SHIFT_MAX)) ? 5'(TAG_SHIFT_MAX) : r_cfg_tb;
        if (r_cfg_hb == 4'd0) w_hb = 5'd1;
        else if ({1'b0, r_cfg_hb} > 5'(HW)) w_hb = 5'(HW);
        else w_hb = {1'b0, r_cfg_hb};
        w_hm_full = {{HW{1'b0}}, 1'b1} << w_hb;
        w_hm = HW'(w_hm_full - 1'b1);
    end

    // index and tag of the incoming word
    logic [BTB_PC_W-1:0]  w_imask, w_tmask, w_ishift, w_tshift;
    logic [EW-1:0]        w_e_in;
    logic [BTB_TAG_W-1:0] w_tag_in;

    always_comb begin
        w_imask  = (32'd1 << w_ib) - 32'd1;
        w_tmask  = (32'd1 << w_tb) - 32'd1;
        w_ishift = (i_req_data.pc >> 2) & w_imask;
        w_tshift = (i_req_data.pc >> (w_ib + 3'd2)) & w_tmask;
        w_e_in   = w_ishift[EW-1:0];
        w_tag_in = w_tshift[BTB_TAG_W-1:0];
    end

    // captured word
    logic                 r_func, r_taken;
    logic [BTB_PC_W-1:0]  r_pc, r_tgt_in, r_pred_next;
    logic [EW-1:0]        r_e;
    logic [BTB_TAG_W-1:0] r_tag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func      <= i_req_data.func;
            r_pc        <= i_req_data.pc;
            r_tgt_in    <= i_req_data.target;
            r_taken     <= i_req_data.taken;
            r_pred_next <= i_req_data.pred_next;
            r_e         <= w_e_in;
            r_tag       <= w_tag_in;
        end
    end

    // entry store: tag, target, local history
    logic [EW-1:0]     w_ent_raddr;
    logic [EWIDTH-1:0] w_ent_rd, w_ent_wd;
    logic              w_ent_we;
    logic [BTB_TAG_W-1:0] w_tag_q;
    logic [BTB_PC_W-1:0]  w_tgt_q;
    logic [HW-1:0]        w_lhist_q;

    assign w_ent_raddr = i_cmd.capture ? w_e_in : r_e;
    assign {w_tag_q, w_tgt_q, w_lhist_q} = w_ent_rd;

    btb_ram #(.WIDTH(EWIDTH), .DEPTH(MAX_ENTRIES), .AW(EW)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (r_e),
        .i_wdata (w_ent_wd),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_ent_rd)
    );

    logic [MAX_ENTRIES-1:0] r_vld, r_hvld;
    logic [HW-1:0]          r_shist;

    // lookup results
    logic                w_hit, w_miss_upd;
    logic                r_hit;
    logic [HW-1:0]       r_hist, r_lhist;
    logic [BTB_PC_W-1:0] r_tgt_st;

    assign w_hit      = r_vld[r_e] && (w_tag_q == r_tag);
    assign w_miss_upd = (r_func == FUNC_UPDATE) && !w_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit    <= w_hit;
            r_lhist  <= w_lhist_q;
            r_tgt_st <= w_tgt_q;
            if (r_cfg_gh) r_hist <= r_shist;
            else if (r_hvld[r_e] && !w_miss_upd) r_hist <= w_lhist_q;
            else r_hist <= '0;
        end
    end

    // counter index
    logic [HW-1:0]       w_share, w_idx;
    logic [EW+HW-1:0]    w_laddr_full, w_lfill_full;
    logic [LAW-1:0]      w_laddr;

    always_comb begin
        case (r_cfg_sm)
            SHARE_LOW:  w_share = r_pc[2 +: HW] & w_hm;
            SHARE_HIGH: w_share = r_pc[16 +: HW] & w_hm;
            default:    w_share = '0;
        endcase
        w_idx = (r_hist & w_hm) ^ (r_cfg_gt ? w_share : '0);
        w_laddr_full = {r_e, w_idx};
        w_laddr = w_laddr_full[LAW-1:0];
    end

    // fill and clear sweep counter
    logic [LAW-1:0] r_fill;
    logic           w_fill_last, w_clear_last;

    assign w_fill_last  = (r_fill[HW-1:0] == {HW{1'b1}});
    assign w_clear_last = (r_fill == LAW'(LDEPTH - 1));
    assign w_lfill_full = {r_e, r_fill[HW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_init_wr) begin
            r_fill <= '0;
        end else if (i_cmd.clear) begin
            r_fill <= w_clear_last ? '0 : r_fill + 1'b1;
        end else if (i_cmd.fill) begin
            r_fill <= w_fill_last ? '0 : r_fill + 1'b1;
        end
    end

    // counter tables
    logic [1:0]     w_lo_rd, w_sh_rd, w_cnt, w_cnt_new;
    logic           w_train, w_lo_we, w_sh_we;
    logic [LAW-1:0] w_lo_waddr;
    logic [1:0]     w_lo_wd, w_sh_wd;
    logic [HW-1:0]  w_sh_waddr;

    assign w_train = i_cmd.finish && (r_func == FUNC_UPDATE);
    assign w_cnt   = r_cfg_gt ? w_sh_rd : w_lo_rd;

    always_comb begin
        w_cnt_new = w_cnt;
        if (r_taken) begin
            if (w_cnt != CNT_MAX) w_cnt_new = w_cnt + 2'd1;
        end else begin
            if (w_cnt != CNT_MIN) w_cnt_new = w_cnt - 2'd1;
        end
        w_lo_we    = i_cmd.clear || i_cmd.fill || (w_train && !r_cfg_gt);
        w_lo_waddr = i_cmd.clear ? r_fill :
                     (i_cmd.fill ? w_lfill_full[LAW-1:0] : w_laddr);
        w_lo_wd    = (i_cmd.clear || i_cmd.fill) ? r_cfg_init : w_cnt_new;
        w_sh_we    = i_cmd.clear || (w_train && r_cfg_gt);
        w_sh_waddr = i_cmd.clear ? r_fill[HW-1:0] : w_idx;
        w_sh_wd    = i_cmd.clear ? r_cfg_init : w_cnt_new;
    end

    btb_ram #(.WIDTH(2), .DEPTH(LDEPTH), .AW(LAW)) u_local_ram (
        .i_clk   (i_clk),
        .i_we    (w_lo_we),
        .i_waddr (w_lo_waddr),
        .i_wdata (w_lo_wd),
        .i_raddr (w_laddr),
        .o_rdata (w_lo_rd)
    );

    btb_ram #(.WIDTH(2), .DEPTH(SLAB), .AW(HW)) u_shared_ram (
        .i_clk   (i_clk),
        .i_we    (w_sh_we),
        .i_waddr (w_sh_waddr),
        .i_wdata (w_sh_wd),
        .i_raddr (w_idx),
        .o_rdata (w_sh_rd)
    );

    // history and entry write-back
    logic [HW-1:0] w_hist_new;
    assign w_hist_new = HW'({r_hist, r_taken}) & w_hm;
    assign w_ent_we   = w_train;
    assign w_ent_wd   = {r_tag, r_tgt_in, (r_cfg_gh ? r_lhist : w_hist_new)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_hvld  <= '0;
            r_shist <= '0;
        end else if (w_train) begin
            r_vld[r_e] <= 1'b1;
            if (r_cfg_gh) r_shist <= w_hist_new;
            else r_hvld[r_e] <= 1'b1;
        end
    end

    // running counts
    logic [BTB_CNT_W-1:0] r_branch, r_flush, w_branch_new, w_flush_new;
    logic [BTB_PC_W-1:0]  w_fall, w_actual;
    logic                 w_mis, w_pred;

    always_comb begin
        w_fall       = r_pc + PC_STEP;
        w_actual     = r_taken ? r_tgt_in : w_fall;
        w_mis        = (r_pred_next != w_actual);
        w_branch_new = r_branch + 32'd1;
        w_flush_new  = r_flush + {31'd0, w_mis};
        w_pred       = r_hit && w_cnt[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_branch <= '0;
            r_flush  <= '0;
        end else if (w_train) begin
            r_branch <= w_branch_new;
            r_flush  <= w_flush_new;
        end
    end

    // result register
    logic r_out_vld;
    t_rsp r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_func == FUNC_UPDATE) begin
                r_out.pred_taken   <= 1'b0;
                r_out.next_pc      <= '0;
                r_out.mispredicted <= w_mis;
                r_out.branch_count <= w_branch_new;
                r_out.flush_count  <= w_flush_new;
            end else begin
                r_out.pred_taken   <= w_pred;
                r_out.next_pc      <= w_pred ? r_tgt_st : w_fall;
                r_out.mispredicted <= 1'b0;
                r_out.branch_count <= r_branch;
                r_out.flush_count  <= r_flush;
            end
        end
    end

    assign o_rsp_valid = r_out_vld;
    assign o_rsp_data  = r_out;

    always_comb begin
        o_sts.init_wr    = w_init_wr;
        o_sts.need_fill  = w_miss_upd && !r_cfg_gt;
        o_sts.fill_last  = w_fill_last;
        o_sts.clear_last = w_clear_last;
        o_sts.out_free   = !r_out_vld || i_rsp_ready;
    end

    `BTB_ASSERT_IMPL(a_finish_free, i_clk, i_rst_n, i_cmd.finish, !r_out_vld || i_rsp_ready, "result overwritten")
    `BTB_ASSERT_NEXT(a_finish_valid, i_clk, i_rst_n, i_cmd.finish, r_out_vld, "result not presented")
    `BTB_ASSERT_NEXT(a_branch_step, i_clk, i_rst_n, w_train, r_branch == $past(r_branch) + 32'd1, "branch count did not advance")
endmodule
`default_nettype wire

>>> rtl/core/btb_two_level_branch_predictor.sv
// Top level: branch target buffer with two-level direction predictor
//
// Request channel i_req carries one word per branch: func selects predict or
// update, with pc, target, taken and pred_next. Response channel o_rsp returns
// one word per request: pred_taken and next_pc for predicts, mispredicted and
// the running branch and flush counts for updates (counts also on predicts).
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data;
// the user must write them only while no request is outstanding; the block
// does not enforce this. A result is registered after the lookup, address
// and count states; an update that allocates an entry with per-entry tables
// also passes through a fill state that refills that entry's counter slab.
// One request is in flight at a time: no new request is taken until the last
// result is written to the output register. The entry store and counter
// table reads are one registered RAM read each.
// After reset, and after each write of initial_state, both counter tables are
// swept with i_req held not ready. A stalled response is held in the output
// register; the next request is still accepted and waits for it to free up.
`timescale 1ns / 1ps
`default_nettype none
module btb_two_level_branch_predictor import btb_pkg::*; #(
    parameter int MAX_ENTRIES = BTB_MAX_ENTRIES,
    parameter int MAX_HISTORY = BTB_MAX_HISTORY
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    btb_req_if.sink                    i_req,
    btb_rsp_if.source                  o_rsp
);
    t_cmd w_cmd;
    t_sts w_sts;

    btb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    btb_dp #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_HISTORY(MAX_HISTORY)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_data  (i_req.data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp_data  (o_rsp.data),
        .i_rsp_ready (o_rsp.ready)
    );
endmodule
`default_nettype wire
